FILE: design/frustum_visibility_test_macros.svh
// Assertion macros for the checker module of the frustum visibility test.
// Each macro expands to one labeled concurrent assertion that is reset-qualified.
`ifndef FRUSTUM_VISIBILITY_TEST_MACROS_SVH
`define FRUSTUM_VISIBILITY_TEST_MACROS_SVH

// Same-cycle implication.
`define FVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fvt_pkg.sv
// ---------------------------------------------------------------------------
// fvt_pkg
// Types and constants shared by the frustum visibility test modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fvt_pkg;

    localparam int PLANE_COUNT    = 6;
    localparam int PLANE_BITS     = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int RADIUS_BITS    = 19;
    localparam int DIST_BITS      = 24;
    localparam int PIDX_BITS      = 3;

    typedef enum logic [1:0] {
        MODE_POINT  = 2'd0,
        MODE_BOX    = 2'd1,
        MODE_SPHERE = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    // Per-item control word that travels along the cell chain.
    typedef struct packed {
        t_mode                        mode;
        logic [PIDX_BITS-1:0]         pidx;
        logic [RADIUS_BITS-1:0]       radius;
        logic                         visible;
        logic signed [DIST_BITS-1:0]  distance;
    } t_ctrl;

    // Plane register write broadcast to every cell.
    typedef struct packed {
        logic                         valid;
        logic [CFG_INDEX_BITS-1:0]    index;
        logic [PLANE_BITS-1:0]        data;
    } t_cfg_wr;

endpackage

`default_nettype wire

FILE: design/fvt_in_if.sv
// ---------------------------------------------------------------------------
// fvt_in_if
// Input word channel: one object bound or distance query per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface fvt_in_if import fvt_pkg::*; #(
    parameter int COORD_BITS = 20
) ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
    logic signed [COORD_BITS-1:0]  box_max_x;
    logic signed [COORD_BITS-1:0]  box_max_y;
    logic signed [COORD_BITS-1:0]  box_max_z;
    logic                          box_valid;
    logic [RADIUS_BITS-1:0]        radius;
    logic [PIDX_BITS-1:0]          plane_index;

    modport source (
        output valid, mode, pos_x, pos_y, pos_z, box_max_x, box_max_y, box_max_z,
               box_valid, radius, plane_index,
        input  ready
    );
    modport sink (
        input  valid, mode, pos_x, pos_y, pos_z, box_max_x, box_max_y, box_max_z,
               box_valid, radius, plane_index,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/fvt_out_if.sv
// ---------------------------------------------------------------------------
// fvt_out_if
// Result word channel: visibility flag and plane distance.
// ---------------------------------------------------------------------------
`default_nettype none

interface fvt_out_if import fvt_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         visible;
    logic signed [DIST_BITS-1:0]  distance;

    modport source (output valid, visible, distance, input ready);
    modport sink   (input valid, visible, distance, output ready);
endinterface

`default_nettype wire

FILE: design/fvt_cfg_if.sv
// ---------------------------------------------------------------------------
// fvt_cfg_if
// Configuration write channel for the six plane registers.
// ---------------------------------------------------------------------------
`default_nettype none

interface fvt_cfg_if import fvt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_BITS-1:0]  index;
    logic [PLANE_BITS-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/fvt_cell.sv
// ---------------------------------------------------------------------------
// fvt_cell
// One plane of the frustum: holds the plane register and tests each passing
// word against it in two stages (products, then sum and compare).
// ---------------------------------------------------------------------------
`default_nettype none

module fvt_cell import fvt_pkg::*; #(
    parameter int COORD_BITS  = 20,
    parameter int NORMAL_BITS = 14,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cfg_wr                     i_cfg,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [5:0][COORD_BITS-1:0]  i_coord,
    input  wire t_ctrl                       i_ctrl,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [5:0][COORD_BITS-1:0]       o_coord,
    output t_ctrl                            o_ctrl
);

    localparam int NF  = NORMAL_BITS - 2;
    localparam int OB  = PLANE_BITS - 3 * NORMAL_BITS;
    localparam int PW  = COORD_BITS + NORMAL_BITS;
    localparam int DW  = OB + NF;
    localparam int RW  = RADIUS_BITS + NF;
    localparam int QW  = DIST_BITS + NF;
    localparam int M1  = (PW > DW) ? PW : DW;
    localparam int M2  = (RW > QW) ? RW : QW;
    localparam int W   = ((M1 > M2) ? M1 : M2) + 3;
    localparam int FW  = W - NF;

    localparam logic signed [FW-1:0] SAT_HI = FW'(2 ** (DIST_BITS - 1) - 1);
    localparam logic signed [FW-1:0] SAT_LO = ~SAT_HI;

    logic [PLANE_BITS-1:0] r_plane;

    logic signed [NORMAL_BITS-1:0] w_norm [3];
    logic signed [OB-1:0]          w_d;
    logic signed [W-1:0]           w_doff;

    logic                          r_va;
    logic                          r_vb;
    logic                          w_ready_a;
    logic                          w_ready_b;
    logic [5:0][COORD_BITS-1:0]    r_coord_a;
    logic [5:0][COORD_BITS-1:0]    r_coord_b;
    t_ctrl                         r_ctrl_a;
    t_ctrl                         r_ctrl_b;
    t_ctrl                         n_ctrl_b;
    logic signed [PW-1:0]          r_prod [6];
    logic signed [PW-1:0]          n_prod [6];

    logic signed [W-1:0]           w_sum;
    logic signed [W-1:0]           w_lim;
    logic signed [FW-1:0]          w_floor;
    logic signed [DIST_BITS-1:0]   w_sat;
    logic                          w_cull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg.valid && i_cfg.index == CFG_INDEX_BITS'(CELL_IDX)) begin
            r_plane <= i_cfg.data;
        end
    end

    assign w_norm[0] = r_plane[NORMAL_BITS-1:0];
    assign w_norm[1] = r_plane[2*NORMAL_BITS-1:NORMAL_BITS];
    assign w_norm[2] = r_plane[3*NORMAL_BITS-1:2*NORMAL_BITS];
    assign w_d       = r_plane[PLANE_BITS-1:3*NORMAL_BITS];
    assign w_doff    = W'(w_d) <<< NF;

    // A stage takes a new word when it is empty or its word moves on.
    assign w_ready_b = !r_vb || i_ready;
    assign w_ready_a = !r_va || w_ready_b;
    assign o_ready   = w_ready_a;

    // Stage A: the normal times both the minimum and maximum coordinate per axis.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_prod[k] = w_norm[k % 3] * $signed(i_coord[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_ready_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_coord_a <= i_coord;
            r_ctrl_a  <= i_ctrl;
            for (int k = 0; k < 6; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    // Stage B: for a box, the larger product on each axis picks the corner
    // farthest in front of the plane; the box is behind only if that one is.
    always_comb begin
        logic signed [PW-1:0] sel;
        w_sum = w_doff;
        for (int k = 0; k < 3; k++) begin
            sel = (r_ctrl_a.mode == MODE_BOX && r_prod[k+3] > r_prod[k]) ?
                  r_prod[k+3] : r_prod[k];
            w_sum = w_sum + W'(sel);
        end
    end

    assign w_lim   = -(W'(r_ctrl_a.radius) <<< NF);
    assign w_cull  = (r_ctrl_a.mode == MODE_SPHERE) ? (w_sum < w_lim) : w_sum[W-1];
    // Dropping the fraction bits of a two's complement value rounds toward
    // minus infinity.
    assign w_floor = w_sum[W-1:NF];

    always_comb begin
        if (w_floor > SAT_HI) begin
            w_sat = DIST_BITS'(SAT_HI);
        end else if (w_floor < SAT_LO) begin
            w_sat = DIST_BITS'(SAT_LO);
        end else begin
            w_sat = DIST_BITS'(w_floor);
        end
    end

    always_comb begin
        n_ctrl_b = r_ctrl_a;
        if (r_ctrl_a.mode != MODE_QUERY && w_cull) begin
            n_ctrl_b.visible = 1'b0;
        end
        if (r_ctrl_a.mode == MODE_QUERY && r_ctrl_a.pidx == PIDX_BITS'(CELL_IDX)) begin
            n_ctrl_b.distance = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_ready_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_va) begin
            r_coord_b <= r_coord_a;
            r_ctrl_b  <= n_ctrl_b;
        end
    end

    assign o_valid = r_vb;
    assign o_coord = r_coord_b;
    assign o_ctrl  = r_ctrl_b;

endmodule

`default_nettype wire

FILE: design/frustum_visibility_test.sv
// ---------------------------------------------------------------------------
// frustum_visibility_test
// Tests points, boxes and spheres against six frustum planes, or returns the
// signed distance of a point to one plane.
// ---------------------------------------------------------------------------
// Usage:
//   i_cfg writes the six plane registers (index 0 left .. 5 far); it is always
//   ready and takes each write as it is offered. Writes with index 6 or 7 are dropped.
//   Write planes only while no word is in flight.
//   i_item takes one word per cycle while the row has room. Each word walks
//   a row of six plane cells, two register stages per cell, to o_result.
//   Sustained throughput is one word per cycle while o_result is ready.
//   The row holds up to 12 words. When o_result stalls, the stalled word holds
//   its output register and later words keep moving up into empty stages, so
//   i_item stays ready until every stage is full.
//   A synchronous reset empties the row and clears all plane registers to 0.
//   visible is 0 for distance queries; distance is 0 for the other modes.
// ---------------------------------------------------------------------------
`default_nettype none

module frustum_visibility_test import fvt_pkg::*; #(
    parameter int COORD_BITS  = 20,
    parameter int NORMAL_BITS = 14
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fvt_cfg_if.sink    i_cfg,
    fvt_in_if.sink     i_item,
    fvt_out_if.source  o_result
);

    logic                        w_valid [PLANE_COUNT+1];
    logic                        w_ready [PLANE_COUNT+1];
    logic [5:0][COORD_BITS-1:0]  w_coord [PLANE_COUNT+1];
    t_ctrl                       w_ctrl  [PLANE_COUNT+1];
    t_cfg_wr                     w_cfg;
    logic                        w_zero_box;

    assign i_cfg.ready = 1'b1;
    assign w_cfg.valid = i_cfg.valid && i_cfg.ready;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;

    // An invalid box collapses to the origin.
    assign w_zero_box = (t_mode'(i_item.mode) == MODE_BOX) && !i_item.box_valid;

    assign w_valid[0]   = i_item.valid;
    assign i_item.ready = w_ready[0];
    assign w_coord[0]   = w_zero_box ? '0 :
                          {i_item.box_max_z, i_item.box_max_y, i_item.box_max_x,
                           i_item.pos_z, i_item.pos_y, i_item.pos_x};

    always_comb begin
        w_ctrl[0]          = '0;
        w_ctrl[0].mode     = t_mode'(i_item.mode);
        w_ctrl[0].pidx     = i_item.plane_index;
        w_ctrl[0].radius   = i_item.radius;
        w_ctrl[0].visible  = 1'b1;
        w_ctrl[0].distance = '0;
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        fvt_cell #(
            .COORD_BITS  (COORD_BITS),
            .NORMAL_BITS (NORMAL_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cfg),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_coord (w_coord[g]),
            .i_ctrl  (w_ctrl[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_coord (w_coord[g+1]),
            .o_ctrl  (w_ctrl[g+1])
        );
    end

    assign w_ready[PLANE_COUNT] = o_result.ready;
    assign o_result.valid       = w_valid[PLANE_COUNT];
    assign o_result.visible     = w_ctrl[PLANE_COUNT].visible &&
                                  (w_ctrl[PLANE_COUNT].mode != MODE_QUERY);
    assign o_result.distance    = w_ctrl[PLANE_COUNT].distance;

endmodule

`default_nettype wire

FILE: design/fvt_checker.sv
// ---------------------------------------------------------------------------
// fvt_checker
// Port-level checks on the result channel of the frustum visibility test.
// ---------------------------------------------------------------------------
`default_nettype none

`include "frustum_visibility_test_macros.svh"

module fvt_checker import fvt_pkg::*; (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        i_ready,
    input wire logic                        i_visible,
    input wire logic signed [DIST_BITS-1:0] i_distance
);

    // A result that is not taken stays offered.
    `FVT_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid, "result valid dropped while stalled")

    // A stalled result keeps its fields.
    `FVT_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_visible) && $stable(i_distance), "result word changed while stalled")

    // Only a query carries a distance, and a query is never visible.
    `FVT_ASSERT_NOW(a_excl, i_clk, i_rst_n, i_valid, !(i_visible && i_distance != '0), "visible and nonzero distance in one word")

    // Reset empties the cell row.
    `FVT_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_valid, "result valid right after reset")

endmodule

bind frustum_visibility_test fvt_checker u_fvt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_result.valid),
    .i_ready    (o_result.ready),
    .i_visible  (o_result.visible),
    .i_distance (o_result.distance)
);

`default_nettype wire

FILE: test/fvt_checker.sv
// ---------------------------------------------------------------------------
// fvt_tb_checker
// Watches the plane write, item and result channels of the frustum
// visibility test, keeps its own copy of the six planes, predicts the result
// word of every accepted item and compares it with what the block returns.
// ---------------------------------------------------------------------------

module fvt_tb_checker import fvt_pkg::*; #(
    parameter int COORD_BITS  = 20,
    parameter int NORMAL_BITS = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fvt_cfg_if    i_cfg,
    fvt_in_if     i_item,
    fvt_out_if    i_result,
    input  logic  i_end_check,
    output int    o_pending,
    output int    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NORM_FRAC    = NORMAL_BITS - 2;
    localparam int     OFFSET_BITS  = PLANE_BITS - 3 * NORMAL_BITS;
    localparam longint DIST_MAX     = (longint'(1) <<< (DIST_BITS - 1)) - 1;
    localparam longint DIST_MIN     = -(longint'(1) <<< (DIST_BITS - 1));
    localparam int     REPORT_LIMIT = 30;

    typedef struct packed {
        logic                         visible;
        logic signed [DIST_BITS-1:0]  distance;
    } t_outcome;

    logic [PLANE_BITS-1:0] plane_regs [PLANE_COUNT];
    t_outcome              expected_words [$];
    int                    fail_count   = 0;
    int                    pending      = 0;
    int                    result_count = 0;
    bit                    end_seen     = 1'b0;

    assign o_pending    = pending;
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    endtask

    // Exact n.p + d, carrying 8 + NORM_FRAC fraction bits.
    function automatic longint plane_distance(input logic [PLANE_BITS-1:0] plane,
                                              input longint x, input longint y,
                                              input longint z);
        logic signed [NORMAL_BITS-1:0] nx, ny, nz;
        logic signed [OFFSET_BITS-1:0] offset;
        nx     = plane[NORMAL_BITS-1:0];
        ny     = plane[2*NORMAL_BITS-1 -: NORMAL_BITS];
        nz     = plane[3*NORMAL_BITS-1 -: NORMAL_BITS];
        offset = plane[PLANE_BITS-1 -: OFFSET_BITS];
        return longint'(nx) * x + longint'(ny) * y + longint'(nz) * z
             + (longint'(offset) <<< NORM_FRAC);
    endfunction

    function automatic t_outcome predict_outcome(input t_mode mode,
                                                 input longint px, input longint py,
                                                 input longint pz, input longint qx,
                                                 input longint qy, input longint qz,
                                                 input logic box_valid,
                                                 input longint radius, input int pidx);
        t_outcome res;
        longint   s, cx, cy, cz;
        bit       behind;
        res.visible  = 1'b1;
        res.distance = '0;
        case (mode)
            MODE_POINT: begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    if (plane_distance(plane_regs[p], px, py, pz) < 0) res.visible = 1'b0;
            end
            MODE_BOX: begin
                // An invalid box collapses to the origin.
                if (!box_valid) begin
                    px = 0; py = 0; pz = 0;
                    qx = 0; qy = 0; qz = 0;
                end
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    behind = 1'b1;
                    for (int c = 0; c < 8; c++) begin
                        cx = (c & 1) ? qx : px;
                        cy = (c & 2) ? qy : py;
                        cz = (c & 4) ? qz : pz;
                        if (plane_distance(plane_regs[p], cx, cy, cz) >= 0) behind = 1'b0;
                    end
                    if (behind) res.visible = 1'b0;
                end
            end
            MODE_SPHERE: begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    if (plane_distance(plane_regs[p], px, py, pz) < -(radius <<< NORM_FRAC))
                        res.visible = 1'b0;
            end
            default: begin
                res.visible = 1'b0;
                if (pidx < PLANE_COUNT) begin
                    // The arithmetic shift rounds toward minus infinity.
                    s = plane_distance(plane_regs[pidx], px, py, pz) >>> NORM_FRAC;
                    if (s > DIST_MAX) s = DIST_MAX;
                    if (s < DIST_MIN) s = DIST_MIN;
                    res.distance = s[DIST_BITS-1:0];
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (plane_regs[p]) plane_regs[p] = '0;
            expected_words.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready && i_cfg.index < PLANE_COUNT)
                plane_regs[i_cfg.index] = i_cfg.data;

            if (i_result.valid && i_result.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word %0d arrived with none expected",
                                              result_count));
                end else begin
                    want = expected_words.pop_front();
                    if (i_result.visible !== want.visible)
                        report_mismatch($sformatf("result word %0d: visible %0b, expected %0b",
                                                  result_count, i_result.visible,
                                                  want.visible));
                    if (i_result.distance !== want.distance)
                        report_mismatch($sformatf("result word %0d: distance %0d, expected %0d",
                                                  result_count, i_result.distance,
                                                  want.distance));
                end
                result_count++;
            end

            if (i_item.valid && i_item.ready)
                expected_words.push_back(predict_outcome(t_mode'(i_item.mode),
                    i_item.pos_x, i_item.pos_y, i_item.pos_z,
                    i_item.box_max_x, i_item.box_max_y, i_item.box_max_z,
                    i_item.box_valid, i_item.radius, i_item.plane_index));
        end

        if (i_end_check && !end_seen) begin
            end_seen = 1'b1;
            if (expected_words.size() != 0)
                report_mismatch($sformatf("%0d expected result words never arrived",
                                          expected_words.size()));
        end
        pending = expected_words.size();
    end

endmodule

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives the frustum visibility test with directed and random items under
// several plane settings, with bursty input and a stalling result side, and
// gives the verdict from the checker's failure count.
// ---------------------------------------------------------------------------

module tb import fvt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS      = 20;
    localparam int NORMAL_BITS     = 14;
    localparam int OFFSET_BITS     = PLANE_BITS - 3 * NORMAL_BITS;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 100;
    localparam int DRAIN_CYCLES    = 24;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 125;
    localparam int DIR_HALF        = 25600;   // 100.0 with 8 fraction bits

    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int NORM_ONE  = 1 << (NORMAL_BITS - 2);
    localparam int NORM_MIN  = -(1 << (NORMAL_BITS - 1));
    localparam int NORM_MAX  = (1 << (NORMAL_BITS - 1)) - 1;
    localparam int OFF_MIN   = -(1 << (OFFSET_BITS - 1));
    localparam int OFF_MAX   = (1 << (OFFSET_BITS - 1)) - 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_NEAR, REG_FAR,
        REG_SPARE_LO, REG_SPARE_HI
    } t_plane_reg;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} t_stall_style;

    typedef struct packed {
        t_mode                         mode;
        logic signed [COORD_BITS-1:0]  px, py, pz;
        logic signed [COORD_BITS-1:0]  qx, qy, qz;
        logic                          box_valid;
        logic [RADIUS_BITS-1:0]        radius;
        logic [PIDX_BITS-1:0]          pidx;
    } t_word;

    typedef struct packed {
        t_plane_reg             index;
        logic [PLANE_BITS-1:0]  data;
    } t_cfg_word;

    typedef logic [PLANE_BITS-1:0] t_plane_set [PLANE_COUNT];

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   end_check;
    int     chk_pending;
    int     chk_fail_count;
    int     idle_cycles = 0;
    int     coord_span  = 1000;
    bit     hold_req    = 1'b0;
    bit     hold_done   = 1'b0;
    t_word  word_q [$];

    fvt_cfg_if                           cfg_ch ();
    fvt_in_if  #(.COORD_BITS(COORD_BITS)) item_ch ();
    fvt_out_if                           result_ch ();

    frustum_visibility_test #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    fvt_tb_checker #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_end_check  (end_check),
        .o_pending    (chk_pending),
        .o_fail_count (chk_fail_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int signed_rand(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int pick_extreme(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
        if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
        if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 19))
            0:             return COORD_BITS'(COORD_MIN);
            1:             return COORD_BITS'(COORD_MAX);
            2:             return '0;
            3:             return clamp_coord(coord_span);
            4:             return clamp_coord(-coord_span);
            5, 6, 7, 8, 9: return COORD_BITS'($urandom);
            default:       return clamp_coord(signed_rand(coord_span));
        endcase
    endfunction

    // Box maximum: mostly above the minimum, sometimes inverted or unrelated.
    function automatic logic signed [COORD_BITS-1:0] box_far_corner(
            input logic signed [COORD_BITS-1:0] lo);
        case ($urandom_range(0, 9))
            0:       return rand_coord();
            1:       return clamp_coord(int'(lo) - int'($urandom_range(0, coord_span)));
            default: return clamp_coord(int'(lo) + int'($urandom_range(0, coord_span)));
        endcase
    endfunction

    function automatic t_word random_word(input t_mode mode);
        t_word w;
        w.mode      = mode;
        w.px        = rand_coord();
        w.py        = rand_coord();
        w.pz        = rand_coord();
        w.qx        = box_far_corner(w.px);
        w.qy        = box_far_corner(w.py);
        w.qz        = box_far_corner(w.pz);
        w.box_valid = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0:       w.radius = '0;
            1:       w.radius = '1;
            2, 3:    w.radius = RADIUS_BITS'($urandom);
            default: w.radius = RADIUS_BITS'($urandom_range(0, coord_span));
        endcase
        w.pidx = PIDX_BITS'($urandom_range(0, (1 << PIDX_BITS) - 1));
        return w;
    endfunction

    function automatic t_word at_point(input t_mode mode, input int x, input int y,
                                       input int z);
        t_word w;
        w    = random_word(mode);
        w.px = clamp_coord(x);
        w.py = clamp_coord(y);
        w.pz = clamp_coord(z);
        return w;
    endfunction

    function automatic logic [PLANE_BITS-1:0] pack_plane(input int nx, ny, nz, offset);
        return {offset[OFFSET_BITS-1:0], nz[NORMAL_BITS-1:0], ny[NORMAL_BITS-1:0],
                nx[NORMAL_BITS-1:0]};
    endfunction

    // A box-shaped frustum of the given half size; skew tilts the normals.
    function automatic t_plane_set frustum_planes(input int half, input int skew);
        t_plane_set planes;
        int         n [3];
        for (int p = 0; p < PLANE_COUNT; p++) begin
            foreach (n[a]) n[a] = (skew == 0) ? 0 : signed_rand(skew);
            n[p / 2] += (p % 2 == 0) ? NORM_ONE : -NORM_ONE;
            planes[p] = pack_plane(n[0], n[1], n[2], half);
        end
        return planes;
    endfunction

    task automatic write_planes(input t_plane_set planes, input bit stray);
        t_cfg_word writes [$];
        foreach (planes[p]) writes.push_back('{index: t_plane_reg'(p), data: planes[p]});
        // Writes past the last plane must leave every plane alone.
        if (stray) begin
            writes.push_back('{index: REG_SPARE_LO, data: {$urandom, $urandom}});
            writes.push_back('{index: REG_SPARE_HI, data: {$urandom, $urandom}});
        end
        foreach (writes[n]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= writes[n].index;
            cfg_ch.data  <= writes[n].data;
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Sends every queued word in bursts of random length with random gaps.
    task automatic drive_words();
        t_word w;
        int    burst_left;
        int    gap;
        burst_left = $urandom_range(1, 24);
        while (word_q.size() != 0) begin
            w = word_q.pop_front();
            item_ch.valid       <= 1'b1;
            item_ch.mode        <= w.mode;
            item_ch.pos_x       <= w.px;
            item_ch.pos_y       <= w.py;
            item_ch.pos_z       <= w.pz;
            item_ch.box_max_x   <= w.qx;
            item_ch.box_max_y   <= w.qy;
            item_ch.box_max_z   <= w.qz;
            item_ch.box_valid   <= w.box_valid;
            item_ch.radius      <= w.radius;
            item_ch.plane_index <= w.pidx;
            do @(posedge i_clk); while (!item_ch.ready);
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
        end
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_word      w;
        t_plane_set planes;
        int         half;

        i_rst_n             = 1'b0;
        end_check           = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_LEFT;
        cfg_ch.data         = '0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_POINT;
        item_ch.pos_x       = '0;
        item_ch.pos_y       = '0;
        item_ch.pos_z       = '0;
        item_ch.box_max_x   = '0;
        item_ch.box_max_y   = '0;
        item_ch.box_max_z   = '0;
        item_ch.box_valid   = 1'b0;
        item_ch.radius      = '0;
        item_ch.plane_index = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All planes are zero after reset, so every distance is zero.
        word_q.push_back(random_word(MODE_POINT));
        word_q.push_back(random_word(MODE_BOX));
        w      = random_word(MODE_QUERY);
        w.pidx = REG_LEFT;
        word_q.push_back(w);
        drive_words();
        wait_drained();

        // Axis-aligned box frustum of half size 100.0.
        write_planes(frustum_planes(DIR_HALF, 0), 1'b0);
        coord_span = 2 * DIR_HALF;
        word_q.push_back(at_point(MODE_POINT, 0, 0, 0));
        word_q.push_back(at_point(MODE_POINT, -DIR_HALF, 0, 0));      // on the left plane
        word_q.push_back(at_point(MODE_POINT, -DIR_HALF - 1, 0, 0));
        word_q.push_back(at_point(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX));
        word_q.push_back(at_point(MODE_POINT, COORD_MIN, COORD_MIN, COORD_MIN));
        // Box straddling the left plane.
        w = at_point(MODE_BOX, -DIR_HALF - 50, -10, -10);
        w.qx = clamp_coord(-DIR_HALF + 5); w.qy = clamp_coord(10); w.qz = clamp_coord(10);
        w.box_valid = 1'b1;
        word_q.push_back(w);
        // Box wholly behind the left plane.
        w = at_point(MODE_BOX, -DIR_HALF - 100, -10, -10);
        w.qx = clamp_coord(-DIR_HALF - 1); w.qy = clamp_coord(10); w.qz = clamp_coord(10);
        w.box_valid = 1'b1;
        word_q.push_back(w);
        // Minimum above maximum on every axis.
        w = at_point(MODE_BOX, 10, 10, 10);
        w.qx = clamp_coord(-10); w.qy = clamp_coord(-10); w.qz = clamp_coord(-10);
        w.box_valid = 1'b1;
        word_q.push_back(w);
        // An invalid box outside the frustum still tests as the origin.
        w = at_point(MODE_BOX, DIR_HALF + 10, DIR_HALF + 10, DIR_HALF + 10);
        w.qx = clamp_coord(COORD_MAX); w.qy = clamp_coord(COORD_MAX);
        w.qz = clamp_coord(COORD_MAX); w.box_valid = 1'b0;
        word_q.push_back(w);
        // Sphere touching the left plane, then one just short of it.
        w = at_point(MODE_SPHERE, -DIR_HALF - 10, 0, 0);
        w.radius = RADIUS_BITS'(10);
        word_q.push_back(w);
        w = at_point(MODE_SPHERE, -DIR_HALF - 10, 0, 0);
        w.radius = RADIUS_BITS'(9);
        word_q.push_back(w);
        w = at_point(MODE_SPHERE, COORD_MIN, 0, 0);
        w.radius = '1;
        word_q.push_back(w);
        w = at_point(MODE_SPHERE, 0, 0, 0);
        w.radius = '0;
        word_q.push_back(w);
        for (int n = 0; n < (1 << PIDX_BITS); n++) begin
            w      = at_point(MODE_QUERY, 30000, -1234, 777);
            w.pidx = PIDX_BITS'(n);
            word_q.push_back(w);
        end
        drive_words();
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    foreach (planes[p])
                        planes[p] = pack_plane(pick_extreme(NORM_MIN, NORM_MAX),
                                               pick_extreme(NORM_MIN, NORM_MAX),
                                               pick_extreme(NORM_MIN, NORM_MAX),
                                               pick_extreme(OFF_MIN, OFF_MAX));
                    coord_span = 300000;
                end
                1: begin
                    half       = $urandom_range(256, 100000);
                    planes     = frustum_planes(half, $urandom_range(0, 1024));
                    coord_span = half + half / 2;
                end
                2: begin
                    foreach (planes[p]) planes[p] = {$urandom, $urandom};
                    coord_span = $urandom_range(1000, 300000);
                end
                default: begin
                    half       = $urandom_range(16, 2000);
                    planes     = frustum_planes(half, 256);
                    coord_span = 2 * half;
                end
            endcase
            write_planes(planes, phase == 0 || $urandom_range(0, 1) == 1);
            if (phase == 0) hold_req = 1'b1;
            repeat (WORDS_PER_PHASE) word_q.push_back(random_word(t_mode'($urandom_range(0, 3))));
            drive_words();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (chk_fail_count == 0) begin
            $display("** frustum_visibility_test: PASSED **");
        end else begin
            $display("** frustum_visibility_test: FAILED **");
        end
        $finish;
    end

    initial begin : result_sink
        t_stall_style style;
        int           left;
        int           tick;
        result_ch.ready = 1'b0;
        style = STALL_NONE;
        left  = 0;
        tick  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // Long back-pressure: the row fills up and the item side must stall.
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                result_ch.ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    style = t_stall_style'($urandom_range(0, 3));
                    left  = $urandom_range(20, 200);
                end
                left--;
                tick++;
                case (style)
                    STALL_NONE:    result_ch.ready <= 1'b1;
                    STALL_RANDOM:  result_ch.ready <= ($urandom_range(0, 99) >= 30);
                    STALL_PATTERN: result_ch.ready <= (tick % 5 < 2);
                    default:       result_ch.ready <= ($urandom_range(0, 99) >= 85);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("** frustum_visibility_test: FAILED **");
            $finish;
        end
    end

endmodule
